@@ hdl/first_match_prefix_route_table_defines.svh @@
// Assertion macros used by the route table datapath.
// They expect a clock named clk and a synchronous reset named rst in scope.
`ifndef FIRST_MATCH_PREFIX_ROUTE_TABLE_DEFINES_SVH
`define FIRST_MATCH_PREFIX_ROUTE_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FMPRT_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FMPRT_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/fmprt_pkg.sv @@
package fmprt_pkg;

  localparam int DEF_MAX_ROUTES = 32;
  localparam int DEF_MAX_PREFIX = 64;

  localparam int CMD_W     = 2;
  localparam int SLOT_W    = 5;
  localparam int POS_W     = 6;
  localparam int BYTE_W    = 8;
  localparam int PLEN_W    = 7;
  localparam int METH_W    = 8;
  localparam int CFG_W     = 6;
  localparam int OUT_IDX_W = 5;

  localparam logic [METH_W-1:0] METH_ANY = '0;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_BYTE    = 2'd0,
    CMD_WR_HEADER  = 2'd1,
    CMD_PATH_BYTE  = 2'd2,
    CMD_EMPTY_PATH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic scan;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic scan_end;
    logic has_result;
    logic out_free;
  } status_t;

endpackage

@@ hdl/fmprt_ctrl.sv @@
module fmprt_ctrl
  import fmprt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] cmd,
  input  status_t          st,
  output logic             in_stall,
  output ctl_t             ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.accept = 1'b1;
          if (cmd_t'(cmd) inside {CMD_PATH_BYTE, CMD_EMPTY_PATH}) begin
            ctl.load   = 1'b1;
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ctl.scan = 1'b1;
        if (st.scan_end) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!st.has_result || st.out_free) begin
          ctl.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/fmprt_datapath.sv @@
`include "first_match_prefix_route_table_defines.svh"

module fmprt_datapath
  import fmprt_pkg::*;
#(
  parameter int MAX_ROUTES = DEF_MAX_ROUTES,
  parameter int MAX_PREFIX = DEF_MAX_PREFIX
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_t                 ctl,
  output status_t              st,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [SLOT_W-1:0]    route_slot,
  input  logic [POS_W-1:0]     byte_position,
  input  logic [BYTE_W-1:0]    byte_value,
  input  logic [PLEN_W-1:0]    prefix_length,
  input  logic [METH_W-1:0]    method_code,
  input  logic                 last,
  input  logic                 cfg_valid,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 found,
  output logic [OUT_IDX_W-1:0] matched_route
);

  localparam int RIW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int PIW = (MAX_PREFIX > 1) ? $clog2(MAX_PREFIX) : 1;
  localparam int LW  = $clog2(MAX_PREFIX + 1);
  localparam int LXW = (LW > PLEN_W) ? LW : PLEN_W;
  localparam int CXW = (RIW > CFG_W) ? RIW : CFG_W;
  localparam int AW  = RIW + PIW;
  localparam int SXW = RIW + SLOT_W;
  localparam int PXW = PIW + POS_W;
  localparam int OXW = RIW + OUT_IDX_W;

  logic [BYTE_W-1:0] byte_mem [2**AW];
  logic [LW-1:0]     len_mem  [2**RIW];
  logic [METH_W-1:0] meth_mem [2**RIW];

  logic [CFG_W-1:0]      active_routes;
  logic [MAX_ROUTES-1:0] alive;
  logic [LW-1:0]         count;
  logic [RIW-1:0]        idx;
  logic                  rd_valid;
  logic [RIW-1:0]        rd_idx;
  logic [BYTE_W-1:0]     rd_byte;
  logic [LW-1:0]         rd_len;
  logic [METH_W-1:0]     rd_meth;
  logic                  hit;
  logic [RIW-1:0]        hit_idx;
  logic                  item_path;
  logic                  item_last;
  logic [BYTE_W-1:0]     item_byte;
  logic [METH_W-1:0]     item_meth;

  logic [SXW-1:0] slot_x;
  logic [PXW-1:0] pos_x;
  logic [LXW-1:0] plen_x;
  logic [LXW-1:0] plen_clamped;
  logic [OXW-1:0] hit_x;
  logic           slot_ok;
  logic           pos_ok;
  logic           wr_byte;
  logic           wr_hdr;
  logic           cnt_lt;
  logic [LW-1:0]  count_eff;
  logic           cmp_en;
  logic           alive_now;
  logic           meth_ok;
  logic           in_range;
  logic           elig;

  assign slot_x       = SXW'(route_slot);
  assign pos_x        = PXW'(byte_position);
  assign plen_x       = LXW'(prefix_length);
  assign slot_ok      = slot_x < SXW'(MAX_ROUTES);
  assign pos_ok       = pos_x < PXW'(MAX_PREFIX);
  assign plen_clamped = (plen_x > LXW'(MAX_PREFIX)) ? LXW'(MAX_PREFIX) : plen_x;
  assign wr_byte      = ctl.accept && (cmd_t'(cmd) == CMD_WR_BYTE) && slot_ok && pos_ok;
  assign wr_hdr       = ctl.accept && (cmd_t'(cmd) == CMD_WR_HEADER) && slot_ok;

  // The count after this byte, saturating at the longest prefix; zero for an empty path request.
  assign cnt_lt    = count < LW'(MAX_PREFIX);
  assign count_eff = !item_path ? '0 : (cnt_lt ? LW'(count + 1'b1) : count);

  assign cmp_en    = item_path && cnt_lt && (count < rd_len);
  assign alive_now = alive[rd_idx] && !(cmp_en && (rd_byte != item_byte));
  assign meth_ok   = (rd_meth == METH_ANY) || (rd_meth == item_meth);
  assign in_range  = CXW'(rd_idx) < CXW'(active_routes);
  assign elig      = in_range && (!item_path || alive_now) && meth_ok && (count_eff >= rd_len);

  assign hit_x = OXW'(hit_idx);

  assign st.scan_end   = idx == RIW'(MAX_ROUTES - 1);
  assign st.has_result = !item_path || item_last;
  assign st.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (wr_byte) begin
      byte_mem[{slot_x[RIW-1:0], pos_x[PIW-1:0]}] <= byte_value;
    end
    if (wr_hdr) begin
      len_mem[slot_x[RIW-1:0]]  <= plen_clamped[LW-1:0];
      meth_mem[slot_x[RIW-1:0]] <= method_code;
    end
    if (ctl.scan) begin
      rd_byte <= byte_mem[{idx, count[PIW-1:0]}];
      rd_len  <= len_mem[idx];
      rd_meth <= meth_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= idx;
    if (ctl.load) begin
      item_path <= cmd_t'(cmd) == CMD_PATH_BYTE;
      item_last <= last;
      item_byte <= byte_value;
      item_meth <= method_code;
    end
    if (rd_valid && elig && !hit) begin
      hit_idx <= rd_idx;
    end
    if (ctl.finish && st.has_result) begin
      found         <= hit;
      matched_route <= hit ? hit_x[OUT_IDX_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_routes <= '0;
      alive         <= '1;
      count         <= '0;
      idx           <= '0;
      rd_valid      <= 1'b0;
      hit           <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      rd_valid <= ctl.scan;
      if (cfg_valid) begin
        active_routes <= cfg_data;
      end
      if (ctl.load) begin
        idx <= '0;
        hit <= 1'b0;
      end else if (ctl.scan) begin
        idx <= idx + 1'b1;
      end
      if (rd_valid) begin
        if (item_path) begin
          alive[rd_idx] <= alive_now;
        end
        if (elig) begin
          hit <= 1'b1;
        end
      end
      if (ctl.finish && item_path) begin
        if (item_last) begin
          alive <= '1;
          count <= '0;
        end else begin
          count <= count_eff;
        end
      end
      if (ctl.finish && st.has_result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `FMPRT_CHECK_NEXT(a_result_loaded, ctl.finish && st.has_result, out_valid, "result word not loaded")
  `FMPRT_CHECK_NEXT(a_path_cleared, ctl.finish && item_path && item_last, (count == '0) && (&alive), "path state not cleared")
  `FMPRT_CHECK_NEXT(a_scan_restart, ctl.load, (idx == '0) && !hit, "scan did not restart")
  `FMPRT_CHECK_NOW(a_miss_zero, out_valid && !found, matched_route == '0, "miss carries nonzero index")

endmodule

@@ hdl/first_match_prefix_route_table.sv @@
// First-match prefix route table.
// Input words arrive on in_valid/in_stall and carry one command each: a route
// prefix byte write, a route header write (length and method), a path byte,
// or an empty path request. Table writes are taken in idle and give no result.
// A path byte or an empty path request scans every route slot through the
// table memories, one route per cycle, so such a word holds the block, and
// no new input word is taken, until its scan and result are done. The last
// path byte and every empty path request produce one result word on
// out_valid/out_stall, loaded after the SCAN, EVAL and DONE states. The
// result gives the lowest eligible route or found low.
// The result sits in an output register. If the receiver stalls, the word is
// held and the next input word is still taken; a later result waits at the
// end of its scan until the register is free.
// The route limit is written on cfg_valid/cfg_data, always ready; the user
// writes it only while no request is in flight; not enforced. Reset fills the
// still-matching set and clears path length, route limit and both channels;
// table contents are left as they are and must be written before use.
module first_match_prefix_route_table
  import fmprt_pkg::*;
#(
  parameter int MAX_ROUTES = DEF_MAX_ROUTES,
  parameter int MAX_PREFIX = DEF_MAX_PREFIX
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [SLOT_W-1:0]    route_slot,
  input  logic [POS_W-1:0]     byte_position,
  input  logic [BYTE_W-1:0]    byte_value,
  input  logic [PLEN_W-1:0]    prefix_length,
  input  logic [METH_W-1:0]    method_code,
  input  logic                 last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 found,
  output logic [OUT_IDX_W-1:0] matched_route,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_W-1:0]     cfg_data
);

  ctl_t    ctl;
  status_t st;

  assign cfg_ready = 1'b1;

  fmprt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .st       (st),
    .in_stall (in_stall),
    .ctl      (ctl)
  );

  fmprt_datapath #(
    .MAX_ROUTES (MAX_ROUTES),
    .MAX_PREFIX (MAX_PREFIX)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .st            (st),
    .cmd           (cmd),
    .route_slot    (route_slot),
    .byte_position (byte_position),
    .byte_value    (byte_value),
    .prefix_length (prefix_length),
    .method_code   (method_code),
    .last          (last),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .found         (found),
    .matched_route (matched_route)
  );

endmodule
